/* rtl/core/tsr_pkg.sv */
// Shared types and constants for the tour segment reversal engine.
// Holds sizes, request codes, the controller state type and the
// command/status structs between controller and datapath. No dependencies.
package tsr_pkg;

  localparam int MAX_CITIES  = 256;
  localparam int POS_W       = $clog2(MAX_CITIES);
  localparam int LEN_W       = $clog2(MAX_CITIES + 1);
  localparam int CITY_W      = 9;
  localparam int FUNC_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CITY_W-1:0] city_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE   = 2'd0,
    FN_READ    = 2'd1,
    FN_REVERSE = 2'd2,
    FN_INVER   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_SPAN_2OPT,
    ST_SPAN_INVER,
    ST_SWAP_RD,
    ST_SWAP_WLO,
    ST_SWAP_WHI,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_WRITE,
    DP_READ,
    DP_SCAN_INIT,
    DP_SCAN,
    DP_SPAN_2OPT,
    DP_SPAN_INVER,
    DP_SWAP_RD,
    DP_SWAP_WLO,
    DP_SWAP_WHI
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   res_load;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  scan_last;
    logic  span_live;
    logic  out_free;
  } dp_stat_t;

endpackage

/* rtl/core/tour_segment_reversal_engine.sv */
// Top level of the tour segment reversal engine: tsr_ctrl plus tsr_datapath.
// Depends on tsr_pkg, tsr_ctrl and tsr_datapath.
//
//   channel  | direction | fields (lowest bit first)
//   ---------+-----------+---------------------------------------------------
//   in_*     | input     | tuser: func; tdata: position_a, position_b,
//            |           |   city_a, city_b
//   out_*    | output    | tdata: read_city, city_missing
//   cfg_*    | input     | wr_data: tour_length
//
// One transaction at a time. A 2-opt reverse takes longer with each swapped
// pair, set by the single write port. An inver-over also takes longer with n,
// the active tour length, set by the one-entry-per-cycle city scan, and with
// each swapped pair. Reset sets tour_length to 256; the tour memory is not
// cleared. A result waits in the output register while the next transaction
// is accepted; its own result then holds until the register frees.
module tour_segment_reversal_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] position_a, [15:8] position_b, [24:16] city_a, [33:25] city_b
  input  logic [tsr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] func
  input  logic [tsr_pkg::FUNC_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [8:0] read_city, [9] city_missing
  output logic [tsr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [tsr_pkg::LEN_W-1:0]        cfg_wr_data
);

  tsr_pkg::dp_cmd_t  cmd;
  tsr_pkg::dp_stat_t stat;

  tsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tsr_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

/* rtl/core/tsr_datapath.sv */
// Datapath of the tour segment reversal engine: tour memory, request
// registers, scan compare stage, span pointers and the result register.
// Depends on tsr_pkg; driven by tsr_ctrl through tsr_pkg::dp_cmd_t.
module tsr_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [tsr_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [tsr_pkg::FUNC_W-1:0]         in_tuser,
  input  logic                               cfg_wr_en,
  input  logic [tsr_pkg::LEN_W-1:0]          cfg_wr_data,
  input  tsr_pkg::dp_cmd_t                   cmd,
  output tsr_pkg::dp_stat_t                  stat,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tsr_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  tsr_pkg::city_t mem [tsr_pkg::MAX_CITIES];

  tsr_pkg::func_t func_r;
  tsr_pkg::pos_t  pa_r, pb_r, lo_r, hi_r, idx_r, cmp_idx_r, pos_a_r, pos_b_r;
  tsr_pkg::city_t ca_r, cb_r, rd_a_r, rd_b_r, out_city_r;
  tsr_pkg::len_t  len_r;
  logic           cmp_vld_r, found_a_r, found_b_r, out_valid_r, out_missing_r;

  tsr_pkg::len_t  n_w;
  tsr_pkg::pos_t  n_m1;
  logic           pa_ok, pb_ok;
  logic           mem_we, re_a, re_b;
  tsr_pkg::pos_t  wa, ra, rb;
  tsr_pkg::city_t wd;
  tsr_pkg::pos_t  lo_nxt, hi_nxt;

  always_comb begin
    if (len_r < tsr_pkg::len_t'(2)) begin
      n_w = tsr_pkg::len_t'(2);
    end else if (len_r > tsr_pkg::len_t'(tsr_pkg::MAX_CITIES)) begin
      n_w = tsr_pkg::len_t'(tsr_pkg::MAX_CITIES);
    end else begin
      n_w = len_r;
    end
  end

  assign n_m1  = tsr_pkg::pos_t'(n_w - tsr_pkg::len_t'(1));
  assign pa_ok = tsr_pkg::len_t'(pa_r) < n_w;
  assign pb_ok = tsr_pkg::len_t'(pb_r) < n_w;

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    re_a   = 1'b0;
    re_b   = 1'b0;
    wa     = lo_r;
    wd     = rd_b_r;
    ra     = lo_r;
    rb     = hi_r;
    unique case (cmd.op)
      tsr_pkg::DP_WRITE: begin
        mem_we = pa_ok;
        wa     = pa_r;
        wd     = ca_r;
      end
      tsr_pkg::DP_READ: begin
        re_a = 1'b1;
        ra   = pa_r;
      end
      tsr_pkg::DP_SCAN: begin
        re_a = 1'b1;
        ra   = idx_r;
      end
      tsr_pkg::DP_SWAP_RD: begin
        re_a = 1'b1;
        re_b = 1'b1;
      end
      tsr_pkg::DP_SWAP_WLO: begin
        mem_we = 1'b1;
      end
      tsr_pkg::DP_SWAP_WHI: begin
        mem_we = 1'b1;
        wa     = hi_r;
        wd     = rd_a_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa] <= wd;
    end
    if (re_a) begin
      rd_a_r <= mem[ra];
    end
    if (re_b) begin
      rd_b_r <= mem[rb];
    end
  end

  // span bounds
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    unique case (cmd.op)
      tsr_pkg::DP_SPAN_2OPT: begin
        if (pa_ok && pb_ok) begin
          lo_nxt = (pa_r > pb_r) ? pb_r : pa_r;
          hi_nxt = (pa_r > pb_r) ? pa_r : pb_r;
        end else begin
          lo_nxt = '0;
          hi_nxt = '0;
        end
      end
      tsr_pkg::DP_SPAN_INVER: begin
        if (pos_a_r <= pos_b_r) begin
          lo_nxt = (pos_a_r == n_m1) ? '0 : tsr_pkg::pos_t'(pos_a_r + 1'b1);
          hi_nxt = (pos_b_r == n_m1) ? '0 : tsr_pkg::pos_t'(pos_b_r + 1'b1);
        end else begin
          lo_nxt = pos_b_r;
          hi_nxt = tsr_pkg::pos_t'(pos_a_r - 1'b1);
        end
      end
      tsr_pkg::DP_SWAP_WHI: begin
        lo_nxt = tsr_pkg::pos_t'(lo_r + 1'b1);
        hi_nxt = tsr_pkg::pos_t'(hi_r - 1'b1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.op == tsr_pkg::DP_LATCH) begin
      func_r <= tsr_pkg::func_t'(in_tuser);
      pa_r   <= in_tdata[7:0];
      pb_r   <= in_tdata[15:8];
      ca_r   <= in_tdata[24:16];
      cb_r   <= in_tdata[33:25];
    end
    if (cmd.op == tsr_pkg::DP_SCAN_INIT) begin
      idx_r <= '0;
    end else if (cmd.op == tsr_pkg::DP_SCAN) begin
      idx_r <= tsr_pkg::pos_t'(idx_r + 1'b1);
    end
    cmp_idx_r <= idx_r;
    if (cmd.op == tsr_pkg::DP_SCAN_INIT) begin
      pos_a_r <= '0;
      pos_b_r <= '0;
    end else if (cmp_vld_r) begin
      if (!found_a_r && rd_a_r == ca_r) begin
        pos_a_r <= cmp_idx_r;
      end
      if (!found_b_r && rd_a_r == cb_r) begin
        pos_b_r <= cmp_idx_r;
      end
    end
    if (cmd.res_load) begin
      out_city_r    <= (func_r == tsr_pkg::FN_READ && pa_ok) ? rd_a_r : '0;
      out_missing_r <= (func_r == tsr_pkg::FN_INVER) && !(found_a_r && found_b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= tsr_pkg::len_t'(tsr_pkg::MAX_CITIES);
      cmp_vld_r   <= 1'b0;
      found_a_r   <= 1'b0;
      found_b_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
      cmp_vld_r <= (cmd.op == tsr_pkg::DP_SCAN);
      if (cmd.op == tsr_pkg::DP_SCAN_INIT) begin
        found_a_r <= 1'b0;
        found_b_r <= 1'b0;
      end else if (cmp_vld_r) begin
        if (rd_a_r == ca_r) begin
          found_a_r <= 1'b1;
        end
        if (rd_a_r == cb_r) begin
          found_b_r <= 1'b1;
        end
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.func      = func_r;
  assign stat.scan_last = (idx_r == n_m1);
  assign stat.span_live = (lo_r < hi_r);
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tsr_pkg::OUT_TDATA_W - tsr_pkg::CITY_W - 1){1'b0}},
                       out_missing_r, out_city_r};

`ifndef SYNTHESIS
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> tsr_pkg::len_t'(wa) < n_w)
    else $error("tour write outside active length");

  a_swap_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tsr_pkg::DP_SWAP_RD) |-> (lo_r < hi_r))
    else $error("swap issued on empty span");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tsr_pkg::DP_SCAN) |-> tsr_pkg::len_t'(idx_r) < n_w)
    else $error("scan past active length");

  a_city_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_load && func_r != tsr_pkg::FN_READ) |=> (out_city_r == '0))
    else $error("read_city nonzero for non-read transaction");
`endif

endmodule

/* rtl/core/tsr_ctrl.sv */
// Controller state machine of the tour segment reversal engine.
// Sequences write, read, 2-opt and inver-over requests over tsr_datapath.
// Depends on tsr_pkg.
module tsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output tsr_pkg::dp_cmd_t  cmd,
  input  tsr_pkg::dp_stat_t stat
);

  tsr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = tsr_pkg::ST_DECODE;
        end
      end
      tsr_pkg::ST_DECODE: begin
        unique case (stat.func)
          tsr_pkg::FN_WRITE:   state_nxt = tsr_pkg::ST_WRITE;
          tsr_pkg::FN_READ:    state_nxt = tsr_pkg::ST_READ;
          tsr_pkg::FN_REVERSE: state_nxt = tsr_pkg::ST_SPAN_2OPT;
          default:             state_nxt = tsr_pkg::ST_SCAN_INIT;
        endcase
      end
      tsr_pkg::ST_WRITE:      state_nxt = tsr_pkg::ST_DONE;
      tsr_pkg::ST_READ:       state_nxt = tsr_pkg::ST_READ_WAIT;
      tsr_pkg::ST_READ_WAIT:  state_nxt = tsr_pkg::ST_DONE;
      tsr_pkg::ST_SCAN_INIT:  state_nxt = tsr_pkg::ST_SCAN;
      tsr_pkg::ST_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = tsr_pkg::ST_SCAN_LAST;
        end
      end
      tsr_pkg::ST_SCAN_LAST:  state_nxt = tsr_pkg::ST_SPAN_INVER;
      tsr_pkg::ST_SPAN_2OPT:  state_nxt = tsr_pkg::ST_SWAP_RD;
      tsr_pkg::ST_SPAN_INVER: state_nxt = tsr_pkg::ST_SWAP_RD;
      tsr_pkg::ST_SWAP_RD: begin
        state_nxt = stat.span_live ? tsr_pkg::ST_SWAP_WLO : tsr_pkg::ST_DONE;
      end
      tsr_pkg::ST_SWAP_WLO:   state_nxt = tsr_pkg::ST_SWAP_WHI;
      tsr_pkg::ST_SWAP_WHI:   state_nxt = tsr_pkg::ST_SWAP_RD;
      tsr_pkg::ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = tsr_pkg::ST_IDLE;
        end
      end
      default:                state_nxt = tsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd.op       = tsr_pkg::DP_NOP;
    cmd.res_load = 1'b0;
    unique case (state_r)
      tsr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = tsr_pkg::DP_LATCH;
        end
      end
      tsr_pkg::ST_WRITE:      cmd.op = tsr_pkg::DP_WRITE;
      tsr_pkg::ST_READ:       cmd.op = tsr_pkg::DP_READ;
      tsr_pkg::ST_SCAN_INIT:  cmd.op = tsr_pkg::DP_SCAN_INIT;
      tsr_pkg::ST_SCAN:       cmd.op = tsr_pkg::DP_SCAN;
      tsr_pkg::ST_SPAN_2OPT:  cmd.op = tsr_pkg::DP_SPAN_2OPT;
      tsr_pkg::ST_SPAN_INVER: cmd.op = tsr_pkg::DP_SPAN_INVER;
      tsr_pkg::ST_SWAP_RD: begin
        if (stat.span_live) begin
          cmd.op = tsr_pkg::DP_SWAP_RD;
        end
      end
      tsr_pkg::ST_SWAP_WLO:   cmd.op = tsr_pkg::DP_SWAP_WLO;
      tsr_pkg::ST_SWAP_WHI:   cmd.op = tsr_pkg::DP_SWAP_WHI;
      tsr_pkg::ST_DONE:       cmd.res_load = stat.out_free;
      default: begin
      end
    endcase
  end

endmodule

/* tb/sv/tb_tour_segment_reversal_engine.sv */
// Testbench for tour_segment_reversal_engine: directed and random tour requests are
// predicted against a mirror of the tour store and checked by a small scoreboard.
// Depends on tsr_pkg and the tour_segment_reversal_engine RTL.
module tb_tour_segment_reversal_engine;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 700;
  localparam int RANDOM_ITEMS = 1270;
  localparam int ERR_REPORTS  = 10;

  typedef struct {
    tsr_pkg::city_t read_city;
    logic           city_missing;
  } tour_result_t;

  class tour_scoreboard;
    tsr_pkg::city_t tour_mirror [tsr_pkg::MAX_CITIES];
    tsr_pkg::len_t  length_reg;
    tour_result_t   predicted_results[$];
    int             error_count;

    function new();
      length_reg  = tsr_pkg::len_t'(tsr_pkg::MAX_CITIES);
      error_count = 0;
      foreach (tour_mirror[i]) tour_mirror[i] = '0;
    endfunction

    function int active_length();
      int n;
      n = int'(length_reg);
      if (n < 2) n = 2;
      if (n > tsr_pkg::MAX_CITIES) n = tsr_pkg::MAX_CITIES;
      return n;
    endfunction

    function void flip_span(int lo, int hi);
      tsr_pkg::city_t t;
      while (lo < hi) begin
        t               = tour_mirror[lo];
        tour_mirror[lo] = tour_mirror[hi];
        tour_mirror[hi] = t;
        lo++;
        hi--;
      end
    endfunction

    function int locate(tsr_pkg::city_t c, int n, inout logic missing);
      for (int i = 0; i < n; i++) begin
        if (tour_mirror[i] == c) return i;
      end
      missing = 1'b1;
      return 0;
    endfunction

    function void flag(string msg);
      error_count++;
      if (error_count <= ERR_REPORTS) $display("mismatch: %s", msg);
    endfunction

    // Apply one accepted transaction to the mirror and queue its result.
    function void note_request(tsr_pkg::func_t f, tsr_pkg::pos_t pa, tsr_pkg::pos_t pb,
                               tsr_pkg::city_t ca, tsr_pkg::city_t cb);
      int           n;
      int           p1;
      int           p2;
      logic         miss;
      tour_result_t r;
      n    = active_length();
      miss = 1'b0;
      r.read_city = '0;
      case (f)
        tsr_pkg::FN_WRITE: begin
          if (pa < n) tour_mirror[pa] = ca;
        end
        tsr_pkg::FN_READ: begin
          if (pa < n) r.read_city = tour_mirror[pa];
        end
        tsr_pkg::FN_REVERSE: begin
          if (pa < n && pb < n) begin
            if (pa > pb) flip_span(int'(pb), int'(pa));
            else flip_span(int'(pa), int'(pb));
          end
        end
        default: begin
          p1 = locate(ca, n, miss);
          p2 = locate(cb, n, miss);
          if (p1 <= p2) flip_span((p1 + 1) % n, (p2 + 1) % n);
          else flip_span(p2, p1 - 1);
        end
      endcase
      r.city_missing = miss;
      predicted_results.insert(predicted_results.size(), r);
    endfunction

    function void check_result(logic [tsr_pkg::OUT_TDATA_W-1:0] d);
      tour_result_t   want;
      tsr_pkg::city_t got_city;
      logic           got_missing;
      got_city    = d[tsr_pkg::CITY_W-1:0];
      got_missing = d[tsr_pkg::CITY_W];
      if (predicted_results.size() == 0) begin
        flag($sformatf("unexpected result read_city=%0d city_missing=%0b",
                       got_city, got_missing));
        return;
      end
      want = predicted_results.pop_front();
      if (got_city !== want.read_city)
        flag($sformatf("read_city expected %0d got %0d", want.read_city, got_city));
      if (got_missing !== want.city_missing)
        flag($sformatf("city_missing expected %0b got %0b", want.city_missing, got_missing));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [tsr_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [tsr_pkg::FUNC_W-1:0]      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tsr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_wr_en = 1'b0;
  logic [tsr_pkg::LEN_W-1:0]       cfg_wr_data = '0;

  tour_scoreboard sb = new();
  int send_idle_pct = 22;
  int recv_idle_pct = 56;
  int stall_cycles  = 0;
  tsr_pkg::len_t boundary_lengths [9] = '{0, 1, 2, 3, 128, 255, 256, 257, 511};

  tour_segment_reversal_engine uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("** tour_segment_reversal_engine: FAILED **");
          $finish;
        end
      end
    end
  end

  task automatic send_request(tsr_pkg::func_t f, tsr_pkg::pos_t pa, tsr_pkg::pos_t pb,
                              tsr_pkg::city_t ca, tsr_pkg::city_t cb);
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk) in_tvalid <= 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {{(tsr_pkg::IN_TDATA_W - 34){1'b0}}, cb, ca, pb, pa};
    do @(posedge clk); while (!in_tready);
    sb.note_request(f, pa, pb, ca, cb);
  endtask

  task automatic drain_results();
    @(negedge clk) in_tvalid <= 1'b0;
    while (sb.predicted_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_tour_length(tsr_pkg::len_t v);
    drain_results();
    repeat (8) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk) cfg_wr_en <= 1'b0;
    sb.length_reg = v;
  endtask

  task automatic random_request();
    int             n;
    int             pick;
    tsr_pkg::func_t f;
    tsr_pkg::pos_t  pa;
    tsr_pkg::pos_t  pb;
    tsr_pkg::city_t ca;
    tsr_pkg::city_t cb;
    n    = sb.active_length();
    pa   = tsr_pkg::pos_t'($urandom_range(0, 255));
    pb   = tsr_pkg::pos_t'($urandom_range(0, 255));
    ca   = tsr_pkg::city_t'($urandom_range(0, 511));
    cb   = tsr_pkg::city_t'($urandom_range(0, 511));
    pick = int'($urandom_range(0, 99));
    if ($urandom_range(0, 99) < 85) begin
      pa = tsr_pkg::pos_t'($urandom_range(0, n - 1));
      pb = tsr_pkg::pos_t'($urandom_range(0, n - 1));
    end
    if (pick < 15) begin
      f = tsr_pkg::FN_WRITE;
      if ($urandom_range(0, 99) < 80) ca = tsr_pkg::city_t'($urandom_range(0, 256));
    end else if (pick < 30) begin
      f = tsr_pkg::FN_READ;
    end else if (pick < 55) begin
      f = tsr_pkg::FN_REVERSE;
    end else begin
      f = tsr_pkg::FN_INVER;
      if ($urandom_range(0, 99) < 85) begin
        ca = sb.tour_mirror[$urandom_range(0, n - 1)];
        cb = sb.tour_mirror[$urandom_range(0, n - 1)];
      end
    end
    send_request(f, pa, pb, ca, cb);
  endtask

  initial begin
    int sent;
    int seg;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // fill the whole store so no entry is read before it is written
    for (int i = 0; i < tsr_pkg::MAX_CITIES; i++)
      send_request(tsr_pkg::FN_WRITE, tsr_pkg::pos_t'(i),
                   tsr_pkg::pos_t'($urandom_range(0, 255)), tsr_pkg::city_t'(i + 1),
                   tsr_pkg::city_t'($urandom_range(0, 511)));

    send_request(tsr_pkg::FN_READ, 0, 0, 0, 0);
    send_request(tsr_pkg::FN_READ, 255, 255, 511, 511);
    send_request(tsr_pkg::FN_WRITE, 255, 0, 511, 0);
    send_request(tsr_pkg::FN_READ, 255, 0, 0, 0);
    send_request(tsr_pkg::FN_WRITE, 255, 0, 256, 0);
    send_request(tsr_pkg::FN_WRITE, 0, 0, 0, 0);
    send_request(tsr_pkg::FN_READ, 0, 0, 0, 0);
    send_request(tsr_pkg::FN_WRITE, 0, 0, 1, 0);
    send_request(tsr_pkg::FN_REVERSE, 5, 5, 0, 0);
    send_request(tsr_pkg::FN_REVERSE, 200, 10, 0, 0);
    send_request(tsr_pkg::FN_REVERSE, 0, 255, 0, 0);
    send_request(tsr_pkg::FN_REVERSE, 255, 0, 0, 0);
    send_request(tsr_pkg::FN_INVER, 0, 0, sb.tour_mirror[3], sb.tour_mirror[10]);
    send_request(tsr_pkg::FN_INVER, 0, 0, sb.tour_mirror[40], sb.tour_mirror[7]);
    send_request(tsr_pkg::FN_INVER, 0, 0, sb.tour_mirror[20], sb.tour_mirror[20]);
    send_request(tsr_pkg::FN_INVER, 0, 0, sb.tour_mirror[255], sb.tour_mirror[0]);
    send_request(tsr_pkg::FN_INVER, 0, 0, sb.tour_mirror[0], sb.tour_mirror[255]);
    send_request(tsr_pkg::FN_INVER, 0, 0, 0, 511);
    send_request(tsr_pkg::FN_INVER, 0, 0, sb.tour_mirror[9], 300);

    set_tour_length(1);
    send_request(tsr_pkg::FN_WRITE, 5, 0, 7, 0);
    send_request(tsr_pkg::FN_READ, 5, 0, 0, 0);
    send_request(tsr_pkg::FN_REVERSE, 0, 5, 0, 0);
    send_request(tsr_pkg::FN_REVERSE, 1, 0, 0, 0);
    send_request(tsr_pkg::FN_INVER, 0, 0, sb.tour_mirror[1], sb.tour_mirror[0]);
    send_request(tsr_pkg::FN_READ, 1, 0, 0, 0);
    set_tour_length(511);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 56 : 0;
      recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 22 : 0;
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        if ($urandom_range(0, 99) < 65)
          set_tour_length(tsr_pkg::len_t'($urandom_range(2, 40)));
        else
          set_tour_length(boundary_lengths[$urandom_range(0, 8)]);
        seg = int'($urandom_range(40, 90));
        for (int k = 0; k < seg && sent < RANDOM_ITEMS / 3; k++) begin
          if ($urandom_range(0, 99) == 0 || (ph == 0 && sent == 100)) drain_results();
          random_request();
          sent++;
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.predicted_results.size() == 0) begin
      $display("** tour_segment_reversal_engine: PASSED **");
    end else begin
      $display("** tour_segment_reversal_engine: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tsr_pkg.sv
rtl/core/tsr_datapath.sv
rtl/core/tsr_ctrl.sv
rtl/core/tour_segment_reversal_engine.sv
tb/sv/tb_tour_segment_reversal_engine.sv
